### hdl/cpa_pkg.sv
package cpa_pkg;

	localparam int NUM_VERTICES = 16;
	localparam int VERTEX_BITS  = 4;
	localparam int COUNT_BITS   = 5;
	localparam int WEIGHT_BITS  = 16;
	localparam int TIME_BITS    = 20;
	localparam int ADDR_BITS    = 2 * VERTEX_BITS;
	localparam int DEPTH        = NUM_VERTICES * NUM_VERTICES;

	localparam logic [WEIGHT_BITS-1:0] NO_EDGE = {WEIGHT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0]  VERTEX_COUNT_RESET = 5'd16;

	// Request from the sequencer to the weight memory
	typedef struct packed {
		logic                   we;
		logic [ADDR_BITS-1:0]   waddr;
		logic [WEIGHT_BITS-1:0] wdata;
		logic [ADDR_BITS-1:0]   raddr;
	} mem_req_t;

endpackage

### hdl/cpa_wmem.sv
module cpa_wmem (
	input  logic                                 clk,
	input  cpa_pkg::mem_req_t                    req,
	output logic [cpa_pkg::WEIGHT_BITS-1:0]      rdata
);

	logic [cpa_pkg::WEIGHT_BITS-1:0] mem [cpa_pkg::DEPTH];

	// One write and one registered read each cycle
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

### hdl/cpa_engine.sv
module cpa_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [4:0]                          cfg_wr_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [23:0]                         s_tdata,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [71:0]                         m_tdata,
	output logic                                m_tlast,
	output cpa_pkg::mem_req_t                   mreq,
	input  logic [cpa_pkg::WEIGHT_BITS-1:0]     rdata
);

	typedef enum logic [10:0] {
		ST_CLEAR = 11'b00000000001,
		ST_LOAD  = 11'b00000000010,
		ST_INDEG = 11'b00000000100,
		ST_PUSH  = 11'b00000001000,
		ST_POP   = 11'b00000010000,
		ST_SCANT = 11'b00000100000,
		ST_CHECK = 11'b00001000000,
		ST_EARLY = 11'b00010000000,
		ST_LATE  = 11'b00100000000,
		ST_EMIT  = 11'b01000000000,
		ST_OUT   = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [4:0]  vc_q;
	logic [4:0]  n_q;
	logic [4:0]  n_ld;
	logic [3:0]  o_q;
	logic [4:0]  x_q;
	logic [3:0]  v_q;
	logic [4:0]  sp_q;
	logic [4:0]  cnt_q;
	logic [8:0]  clr_q;
	logic        pend_s1;
	logic [3:0]  idx_s1;
	logic [19:0] acc_q;
	logic [19:0] len_q;
	logic        any_q;
	logic [15:0] crit_q;
	logic [71:0] tdata_q;
	logic        tlast_q;

	logic [4:0]  indeg_q [cpa_pkg::NUM_VERTICES];
	logic [3:0]  stack_q [cpa_pkg::NUM_VERTICES];
	logic [3:0]  topo_q  [cpa_pkg::NUM_VERTICES];
	logic [3:0]  pos_q   [cpa_pkg::NUM_VERTICES];
	logic [19:0] earl_q  [cpa_pkg::NUM_VERTICES];
	logic [19:0] lat_q   [cpa_pkg::NUM_VERTICES];

	logic        issue;
	logic        done;
	logic        w_nz;
	logic [20:0] sum;
	logic [19:0] w20;
	logic [19:0] cand;
	logic [4:0]  nd;
	logic [15:0] wfix;
	logic        last_k;

	// Clamp the vertex count and decode the scan controls
	always_comb begin
		if (vc_q == 5'd0) n_ld = 5'd1;
		else if (vc_q > 5'd16) n_ld = 5'd16;
		else n_ld = vc_q;
		issue  = x_q < n_q;
		done   = !issue && !pend_s1;
		w_nz   = rdata != '0;
		w20    = {4'd0, rdata};
		sum    = {1'b0, earl_q[idx_s1]} + {1'b0, w20};
		cand   = (lat_q[idx_s1] >= w20) ? lat_q[idx_s1] - w20 : 20'd0;
		nd     = indeg_q[idx_s1] - 5'd1;
		wfix   = (s_tdata[23:8] == cpa_pkg::NO_EDGE) ? 16'd0 : s_tdata[23:8];
		last_k = ({1'b0, o_q} + 5'd1) == n_q;
	end

	// Drive the weight memory port; a word sits at {source, target}
	always_comb begin
		mreq.we    = (state_q == ST_CLEAR) || (state_q == ST_LOAD && s_tvalid);
		mreq.waddr = (state_q == ST_CLEAR) ? clr_q[7:0] : {s_tdata[3:0], s_tdata[7:4]};
		mreq.wdata = (state_q == ST_CLEAR) ? 16'd0 : wfix;
		unique case (state_q)
			ST_INDEG, ST_EMIT: mreq.raddr = {o_q, x_q[3:0]};
			ST_EARLY:          mreq.raddr = {x_q[3:0], v_q};
			default:           mreq.raddr = {v_q, x_q[3:0]};
		endcase
	end

	assign s_tready = state_q == ST_LOAD;
	assign m_tvalid = state_q == ST_OUT;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;

	// Payload arrays and result register
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				if (s_tvalid && s_tlast) begin
					for (int i = 0; i < cpa_pkg::NUM_VERTICES; i++) indeg_q[i] <= 5'd0;
				end
			end
			ST_INDEG: begin
				if (pend_s1 && w_nz) indeg_q[idx_s1] <= indeg_q[idx_s1] + 5'd1;
			end
			ST_PUSH: begin
				if (issue && indeg_q[x_q[3:0]] == 5'd0) stack_q[sp_q[3:0]] <= x_q[3:0];
			end
			ST_POP: begin
				if (sp_q != 5'd0 && cnt_q < n_q) begin
					topo_q[cnt_q[3:0]] <= stack_q[sp_q[3:0] - 4'd1];
					pos_q[stack_q[sp_q[3:0] - 4'd1]] <= cnt_q[3:0];
				end
			end
			ST_SCANT: begin
				if (pend_s1 && w_nz && indeg_q[idx_s1] != 5'd0) begin
					indeg_q[idx_s1] <= nd;
					if (nd == 5'd0 && !sp_q[4]) stack_q[sp_q[3:0]] <= idx_s1;
				end
			end
			ST_CHECK: begin
				if (cnt_q < n_q) tdata_q <= {7'd0, 1'b1, 64'd0};
			end
			ST_EARLY: begin
				if (done) earl_q[v_q] <= acc_q;
			end
			ST_LATE: begin
				if (done) lat_q[v_q] <= any_q ? acc_q : len_q;
			end
			ST_EMIT: begin
				if (done) begin
					tdata_q <= {7'd0, 1'b0, crit_q, lat_q[o_q], earl_q[o_q], pos_q[o_q], o_q};
				end
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			vc_q    <= cpa_pkg::VERTEX_COUNT_RESET;
			n_q     <= 5'd1;
			o_q     <= '0;
			x_q     <= '0;
			v_q     <= '0;
			sp_q    <= '0;
			cnt_q   <= '0;
			clr_q   <= '0;
			pend_s1 <= 1'b0;
			idx_s1  <= '0;
			acc_q   <= '0;
			len_q   <= '0;
			any_q   <= 1'b0;
			crit_q  <= '0;
			tlast_q <= 1'b0;
		end else begin
			if (cfg_wr_en) vc_q <= cfg_wr_data;
			// Advance the read pipeline in scanning states
			if (state_q == ST_INDEG || state_q == ST_SCANT || state_q == ST_EARLY ||
			    state_q == ST_LATE || state_q == ST_EMIT) begin
				pend_s1 <= issue;
				idx_s1  <= x_q[3:0];
				if (issue) x_q <= x_q + 5'd1;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 9'd1;
					if (clr_q == 9'd255) begin
						clr_q   <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (s_tvalid && s_tlast) begin
						n_q     <= n_ld;
						o_q     <= '0;
						x_q     <= '0;
						state_q <= ST_INDEG;
					end
				end
				ST_INDEG: begin
					if (done) begin
						x_q <= '0;
						if (last_k) begin
							sp_q    <= '0;
							cnt_q   <= '0;
							state_q <= ST_PUSH;
						end else begin
							o_q <= o_q + 4'd1;
						end
					end
				end
				ST_PUSH: begin
					if (issue) begin
						x_q <= x_q + 5'd1;
						if (indeg_q[x_q[3:0]] == 5'd0) sp_q <= sp_q + 5'd1;
					end else begin
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					if (sp_q != 5'd0 && cnt_q < n_q) begin
						v_q     <= stack_q[sp_q[3:0] - 4'd1];
						sp_q    <= sp_q - 5'd1;
						cnt_q   <= cnt_q + 5'd1;
						x_q     <= '0;
						state_q <= ST_SCANT;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_SCANT: begin
					if (pend_s1 && w_nz && indeg_q[idx_s1] != 5'd0 && nd == 5'd0 && !sp_q[4]) begin
						sp_q <= sp_q + 5'd1;
					end
					if (done) state_q <= ST_POP;
				end
				ST_CHECK: begin
					if (cnt_q < n_q) begin
						tlast_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						o_q     <= '0;
						v_q     <= topo_q[0];
						x_q     <= '0;
						acc_q   <= '0;
						len_q   <= '0;
						state_q <= ST_EARLY;
					end
				end
				ST_EARLY: begin
					if (pend_s1 && w_nz && sum > {1'b0, acc_q}) acc_q <= sum[19:0];
					if (done) begin
						if (acc_q > len_q) len_q <= acc_q;
						acc_q <= '0;
						x_q   <= '0;
						if (last_k) begin
							o_q     <= n_q[3:0] - 4'd1;
							v_q     <= topo_q[n_q[3:0] - 4'd1];
							any_q   <= 1'b0;
							state_q <= ST_LATE;
						end else begin
							o_q <= o_q + 4'd1;
							v_q <= topo_q[o_q + 4'd1];
						end
					end
				end
				ST_LATE: begin
					if (pend_s1 && w_nz) begin
						if (!any_q || cand < acc_q) acc_q <= cand;
						any_q <= 1'b1;
					end
					if (done) begin
						acc_q <= '0;
						any_q <= 1'b0;
						x_q   <= '0;
						if (o_q == 4'd0) begin
							crit_q  <= '0;
							state_q <= ST_EMIT;
						end else begin
							o_q <= o_q - 4'd1;
							v_q <= topo_q[o_q - 4'd1];
						end
					end
				end
				ST_EMIT: begin
					if (pend_s1 && w_nz && lat_q[idx_s1] >= w20 &&
					    lat_q[idx_s1] - w20 == earl_q[o_q]) begin
						crit_q[idx_s1] <= 1'b1;
					end
					if (done) begin
						tlast_q <= last_k;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						if (tlast_q) begin
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end else begin
							o_q     <= o_q + 4'd1;
							x_q     <= '0;
							crit_q  <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

### hdl/critical_path_analyzer_core.sv
// Critical path analyzer for an activity-on-edge network of up to 16 vertices.
// Edge transfers on the s_ side write one word of the weight memory each and
// are taken one per cycle; the transfer with s_tlast set also starts the
// analysis, and the input stays stalled until the results are delivered and
// the memory is cleared. The analysis walks the weight memory one word per
// cycle through its single read port: in-degree count, stack order, earliest
// and latest times and the critical-edge scan, which also waits on the m_ side
// handshake, followed by a sweep that clears all 256 words of the memory.
// The same sweep runs after reset before the first edge is taken. A cyclic
// graph gives one result with cycle_error set; otherwise one result per
// vertex in index order, m_tlast on the final one. vertex_count is to be
// written through cfg_wr_en / cfg_wr_data only while the block is idle; the
// block itself does not enforce this. 0 acts as 1, above 16 as 16.
module critical_path_analyzer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,  // vertex_count
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,      // edge_source, edge_target, edge_weight
	input  logic        s_tlast,      // last_edge
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,      // vertex, topo_position, earliest_time,
	                                  // latest_time, critical_successors, cycle_error
	output logic        m_tlast       // last_result
);

	cpa_pkg::mem_req_t               mreq;
	logic [cpa_pkg::WEIGHT_BITS-1:0] rdata;

	cpa_wmem u_wmem (
		.clk   (clk),
		.req   (mreq),
		.rdata (rdata)
	);

	cpa_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.mreq        (mreq),
		.rdata       (rdata)
	);

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

	typedef struct packed {
		logic [3:0]  src;
		logic [3:0]  dst;
		logic [15:0] weight;
		logic        last;
	} edge_item_t;

	typedef struct {
		logic [3:0]  vertex;
		logic [3:0]  position;
		logic [19:0] earliest_time;
		logic [19:0] latest_time;
		logic [15:0] critical;
		logic        cycle_error;
		logic        last;
	} vertex_report_t;

	localparam int SETTLE_CYCLES = 2000;
	localparam longint CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [4:0]  cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        m_tlast;

	critical_path_analyzer_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// predictor state
	logic [15:0] weights [16][16];
	int          active_vertices;
	edge_item_t      pending_edges[$];
	vertex_report_t  expected_reports[$];
	int  error_count;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  hold_off_cycles;
	longint cycle_count;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// abort on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// count down the long receiver hold-off
	always @(posedge clk) begin
		if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
	end

	// apply one edge transfer to the predictor
	task automatic predict_edge(input edge_item_t it);
		int n, count, sp, v;
		int indeg[16], order[16], pos[16], stack[16];
		logic [19:0] est[16], lst[16];
		logic [19:0] len, e, best, cand;
		logic [15:0] crit;
		bit any;
		vertex_report_t r;
		weights[it.src][it.dst] = (it.weight == cpa_pkg::NO_EDGE) ? 16'd0 : it.weight;
		if (!it.last) return;
		n = active_vertices;
		if (n < 1) n = 1;
		if (n > 16) n = 16;
		for (int j = 0; j < n; j++) begin
			indeg[j] = 0;
			for (int i = 0; i < n; i++)
				if (weights[i][j] != 0) indeg[j]++;
		end
		sp = 0;
		for (int i = 0; i < n; i++)
			if (indeg[i] == 0) begin
				stack[sp] = i;
				sp++;
			end
		count = 0;
		while (sp > 0 && count < n) begin
			sp--;
			v = stack[sp];
			order[count] = v;
			pos[v] = count;
			count++;
			for (int j = 0; j < n; j++)
				if (weights[v][j] != 0 && indeg[j] > 0) begin
					indeg[j]--;
					if (indeg[j] == 0 && sp < 16) begin
						stack[sp] = j;
						sp++;
					end
				end
		end
		if (count < n) begin
			r = '{4'd0, 4'd0, 20'd0, 20'd0, 16'd0, 1'b1, 1'b1};
			expected_reports.push_back(r);
		end else begin
			len = 0;
			for (int k = 0; k < n; k++) begin
				v = order[k];
				e = 0;
				for (int i = 0; i < n; i++)
					if (weights[i][v] != 0 && est[i] + weights[i][v] > e)
						e = est[i] + weights[i][v];
				est[v] = e;
				if (e > len) len = e;
			end
			for (int k = n - 1; k >= 0; k--) begin
				v = order[k];
				any = 0;
				best = 0;
				for (int j = 0; j < n; j++)
					if (weights[v][j] != 0) begin
						cand = (lst[j] >= weights[v][j]) ? lst[j] - weights[v][j] : 20'd0;
						if (!any || cand < best) best = cand;
						any = 1;
					end
				lst[v] = any ? best : len;
			end
			for (int i = 0; i < n; i++) begin
				crit = 0;
				for (int j = 0; j < n; j++)
					if (weights[i][j] != 0 && lst[j] >= weights[i][j]
					    && lst[j] - weights[i][j] == est[i])
						crit[j] = 1'b1;
				r = '{i[3:0], pos[i][3:0], est[i], lst[i], crit, 1'b0, (i == n - 1)};
				expected_reports.push_back(r);
			end
		end
		foreach (weights[a, b]) weights[a][b] = 0;
	endtask

	// drive edge transfers from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) predict_edge(pending_edges.pop_front());
			if ((!s_tvalid || s_tready) && pending_edges.size() > 0
			    && $urandom_range(99) >= send_idle_pct) begin
				edge_item_t nx;
				nx = pending_edges[0];
				s_tvalid <= 1'b1;
				s_tdata  <= {nx.weight, nx.dst, nx.src};
				s_tlast  <= nx.last;
			end else if (!s_tvalid || s_tready) begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// check results and set receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_reports.size() == 0) begin
					$error("unexpected result %h", m_tdata);
					error_count++;
				end else begin
					vertex_report_t x;
					x = expected_reports.pop_front();
					if (m_tdata[3:0] !== x.vertex) begin
						$error("vertex exp %0d got %0d", x.vertex, m_tdata[3:0]);
						error_count++;
					end
					if (m_tdata[7:4] !== x.position) begin
						$error("topo_position exp %0d got %0d", x.position, m_tdata[7:4]);
						error_count++;
					end
					if (m_tdata[27:8] !== x.earliest_time) begin
						$error("earliest_time exp %0d got %0d", x.earliest_time, m_tdata[27:8]);
						error_count++;
					end
					if (m_tdata[47:28] !== x.latest_time) begin
						$error("latest_time exp %0d got %0d", x.latest_time, m_tdata[47:28]);
						error_count++;
					end
					if (m_tdata[63:48] !== x.critical) begin
						$error("critical_successors exp %h got %h", x.critical, m_tdata[63:48]);
						error_count++;
					end
					if (m_tdata[64] !== x.cycle_error) begin
						$error("cycle_error exp %0d got %0d", x.cycle_error, m_tdata[64]);
						error_count++;
					end
					if (m_tlast !== x.last) begin
						$error("last_result exp %0d got %0d", x.last, m_tlast);
						error_count++;
					end
				end
			end
			if (hold_off_cycles > 0) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic edge_item_t make_edge(int s, int d, int w, bit l);
		edge_item_t it;
		it.src = s[3:0];
		it.dst = d[3:0];
		it.weight = w[15:0];
		it.last = l;
		return it;
	endfunction

	// queue one graph: mostly forward edges (acyclic), sometimes a back edge
	task automatic queue_graph(int n, int edges, bit allow_cycle);
		int s, d, w;
		for (int e = 0; e < edges; e++) begin
			s = $urandom_range(15);
			d = $urandom_range(15);
			if (n > 1 && $urandom_range(9) != 0) begin
				s = $urandom_range(n - 2);
				d = $urandom_range(n - 1, s + 1);
			end
			case ($urandom_range(9))
				0: w = 0;
				1: w = 16'hFFFF;
				2: w = $urandom_range(16'hFFFE, 16'hF000);
				default: w = $urandom_range(50, 1);
			endcase
			if (!allow_cycle && w != 0 && w != 16'hFFFF && s >= d && s < n && d < n)
				w = 0;
			pending_edges.push_back(make_edge(s, d, w, e == edges - 1));
		end
	endtask

	task automatic wait_drained();
		while (pending_edges.size() > 0 || s_tvalid || expected_reports.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertex_count(int value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value[4:0];
		active_vertices = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int counts[6] = '{16, 1, 0, 31, 5, 9};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		error_count = 0;
		cycle_count = 0;
		hold_off_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		active_vertices = 16;
		foreach (weights[a, b]) weights[a][b] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: chain with extreme weights, parallel paths, clears, self loop, cycle
		pending_edges.push_back(make_edge(0, 1, 16'hFFFE, 0));
		pending_edges.push_back(make_edge(1, 2, 16'hFFFE, 0));
		pending_edges.push_back(make_edge(0, 2, 3, 0));
		pending_edges.push_back(make_edge(2, 15, 1, 0));
		pending_edges.push_back(make_edge(3, 15, 16'hFFFF, 0));
		pending_edges.push_back(make_edge(4, 5, 7, 0));
		pending_edges.push_back(make_edge(4, 5, 0, 0));
		pending_edges.push_back(make_edge(14, 15, 5, 1));
		pending_edges.push_back(make_edge(6, 6, 9, 1));
		pending_edges.push_back(make_edge(1, 2, 4, 0));
		pending_edges.push_back(make_edge(2, 1, 4, 1));
		pending_edges.push_back(make_edge(15, 15, 16'hFFFF, 1));
		for (int k = 0; k < 15; k++)
			pending_edges.push_back(make_edge(k, k + 1, 16'hFFFE, k == 14));
		wait_drained();

		// random phases over several vertex counts and idle profiles
		for (int p = 0; p < 6; p++) begin
			write_vertex_count(counts[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			if (p == 2) hold_off_cycles = 3000;
			for (int g = 0; g < 9; g++)
				queue_graph((counts[p] < 1) ? 1 : (counts[p] > 16 ? 16 : counts[p]),
				            $urandom_range(14, 1), $urandom_range(5) == 0);
			wait_drained();
		end

		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### files.f
hdl/cpa_pkg.sv
hdl/cpa_wmem.sv
hdl/cpa_engine.sv
hdl/critical_path_analyzer_core.sv
tb/tb.sv
